// ----- sv/pkrl_pkg.sv -----
// Shared types, constants and helpers of the per-key rate limiter.
package pkrl_pkg;

  // Default geometry of the entry store
  localparam int unsigned SETS_DEF = 256;
  localparam int unsigned WAYS_DEF = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_idx_t;

  localparam logic [15:0] WINDOW_RST = 16'd60;
  localparam logic [15:0] LIMIT_RST  = 16'd60;

  // Request modes
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_PEEK  = 1'b1;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Request word
  typedef struct packed {
    logic        mode;
    logic [31:0] user_key;
    logic [31:0] now_seconds;
  } req_t;

  // Result word
  typedef struct packed {
    logic        allowed;
    logic [15:0] remaining;
    logic        untracked;
  } res_t;

  // One way of a set
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] count;
    logic [31:0] start;
  } entry_t;

  // Update decision handed back to the controller
  typedef struct packed {
    logic we;
    res_t res;
  } upd_ctl_t;

  function automatic bit is_pow2(input int unsigned n);
    return (n & (n - 1)) == 0;
  endfunction

endpackage

// ----- sv/pkrl_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
interface pkrl_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/per_key_fixed_window_rate_limiter_core.sv -----
// Per-key fixed-window rate limiter: controller, configuration and result register.
// Flow: accept, then a hash state when SETS is not a power of two (the reciprocal
// multiply that forms key modulo SETS), then the update state, which fills the result register.
// A new word is taken only after the last one has finished the read-modify-write of its set row.
// Reset: synchronous, active low; a clearing sweep of every set follows,
// during which in_req.ready stays low and configuration writes are taken.
module per_key_fixed_window_rate_limiter_core #(
  parameter int unsigned SETS = pkrl_pkg::SETS_DEF,
  parameter int unsigned WAYS = pkrl_pkg::WAYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pkrl_stream_if.sink                       in_req,
  pkrl_stream_if.source                     out_res,
  input  logic                              cfg_we,
  input  logic [pkrl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pkrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pkrl_pkg::*;

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam bit          POW2  = is_pow2(SETS);

  typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_UPD} state_t;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [SET_W-1:0]      set_r;
  logic                  out_valid_r;
  res_t                  out_data_r;
  logic [15:0]           window_r;
  logic [15:0]           limit_r;

  logic                  in_acc;
  logic                  rd_en;
  logic                  wr_en;
  logic [SET_W-1:0]      rd_addr;
  logic [SET_W-1:0]      set_now;
  logic [SET_W-1:0]      set_late;
  logic                  mem_busy;
  entry_t [WAYS-1:0]     rd_row;
  entry_t [WAYS-1:0]     new_row;
  upd_ctl_t              upd;

  // Handshake
  assign in_req.ready = (state_r == ST_IDLE) && !mem_busy && (!out_valid_r || out_res.ready);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  // Memory access control
  assign rd_en   = (in_acc && POW2) || (state_r == ST_HASH);
  assign rd_addr = (state_r == ST_HASH) ? set_late : set_now;
  assign wr_en   = (state_r == ST_UPD) && upd.we;

  pkrl_set_hash #(.SETS(SETS)) u_hash (
    .clk      (clk),
    .load     (in_acc),
    .user_key (in_req.data.user_key),
    .set_now  (set_now),
    .set_late (set_late)
  );

  pkrl_set_mem #(.SETS(SETS), .WAYS(WAYS)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (set_r),
    .wr_row  (new_row),
    .busy    (mem_busy)
  );

  pkrl_update #(.WAYS(WAYS)) u_upd (
    .row            (rd_row),
    .req            (req_r),
    .window_seconds (window_r),
    .message_limit  (limit_r),
    .new_row        (new_row),
    .ctl            (upd)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = POW2 ? ST_UPD : ST_HASH;
      end
      ST_HASH: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, request, result and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RST;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD) begin
        out_valid_r <= 1'b1;
        out_data_r  <= upd.res;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        req_r <= in_req.data;
        set_r <= set_now;
      end else if (state_r == ST_HASH) begin
        set_r <= set_late;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW: window_r <= cfg_wdata;
          CFG_LIMIT:  limit_r  <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  // Result register is free whenever an update completes
  a_upd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> !out_valid_r)
    else $error("update reached with result register occupied");

  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |=> out_valid_r && state_r == ST_IDLE)
    else $error("update did not produce a result");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted word left no work in flight");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !rd_en && !wr_en)
    else $error("memory access during clearing sweep");

  a_pow2_direct: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && POW2 |=> state_r == ST_UPD)
    else $error("masked set index did not go straight to update");

endmodule

// ----- sv/pkrl_set_hash.sv -----
// Set index: user key modulo SETS, by mask or by reciprocal multiply.
module pkrl_set_hash #(
  parameter int unsigned SETS = pkrl_pkg::SETS_DEF
) (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] user_key,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_now,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_late
);
  import pkrl_pkg::*;

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  logic [SET_W-1:0] key_lo_r;

  // Low key bits kept for the late remainder
  always_ff @(posedge clk) begin
    if (load) begin
      key_lo_r <= user_key[SET_W-1:0];
    end
  end

  // Valid only for a power-of-two set count
  assign set_now = user_key[SET_W-1:0] & SET_W'(SETS - 1);

  generate
    if (is_pow2(SETS)) begin : g_mask
      assign set_late = key_lo_r & SET_W'(SETS - 1);
    end else begin : g_recip
      // q = floor(key * ceil(2^(32+L)/SETS) / 2^(32+L)), exact for 32-bit keys
      localparam int unsigned L = $clog2(SETS);
      localparam logic [63:0] MAGIC64 =
        ((64'd1 << (32 + L)) + 64'(SETS) - 64'd1) / 64'(SETS);
      localparam logic [32:0] MAGIC = MAGIC64[32:0];

      logic [64:0]      prod;
      logic [SET_W-1:0] q_lo_r;

      assign prod = 65'(user_key) * 65'(MAGIC);

      always_ff @(posedge clk) begin
        if (load) begin
          q_lo_r <= prod[32 + L +: SET_W];
        end
      end

      // Remainder fits SET_W bits, so low bits of key - q*SETS suffice
      assign set_late = key_lo_r - SET_W'(q_lo_r * SET_W'(SETS));
    end
  endgenerate

endmodule

// ----- sv/pkrl_set_mem.sv -----
// Set store: one row of WAYS entries per set, clearing sweep after reset.
module pkrl_set_mem #(
  parameter int unsigned SETS = pkrl_pkg::SETS_DEF,
  parameter int unsigned WAYS = pkrl_pkg::WAYS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       rd_en,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] rd_addr,
  output pkrl_pkg::entry_t [WAYS-1:0]                rd_row,
  input  logic                                       wr_en,
  input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] wr_addr,
  input  pkrl_pkg::entry_t [WAYS-1:0]                wr_row,
  output logic                                       busy
);
  import pkrl_pkg::*;

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  typedef entry_t [WAYS-1:0] row_t;

  row_t             row_mem [SETS];
  row_t             rd_row_r;
  logic             clearing_r;
  logic [SET_W-1:0] clr_idx_r;

  // Clearing sweep, one row a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      if (clr_idx_r == SET_W'(SETS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      row_mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= row_mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;
  assign busy   = clearing_r;

endmodule

// ----- sv/pkrl_update.sv -----
// Way match, window check and count update of one set row.
module pkrl_update #(
  parameter int unsigned WAYS = pkrl_pkg::WAYS_DEF
) (
  input  pkrl_pkg::entry_t [WAYS-1:0] row,
  input  pkrl_pkg::req_t              req,
  input  logic [15:0]                 window_seconds,
  input  logic [15:0]                 message_limit,
  output pkrl_pkg::entry_t [WAYS-1:0] new_row,
  output pkrl_pkg::upd_ctl_t          ctl
);
  import pkrl_pkg::*;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic             hit;
  logic             have_free;
  logic [WAY_W-1:0] hit_w;
  logic [WAY_W-1:0] free_w;
  entry_t           sel;
  logic [31:0]      elapsed;
  logic             expired;
  logic [15:0]      count_inc;
  logic [15:0]      count_eff;

  function automatic logic [15:0] budget_left(input logic [15:0] c, input logic [15:0] lim);
    return (c >= lim) ? 16'd0 : lim - c;
  endfunction

  // First matching way and first free way
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_w     = '0;
    free_w    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[w].valid) begin
        if (!hit && row[w].key == req.user_key) begin
          hit   = 1'b1;
          hit_w = WAY_W'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_w    = WAY_W'(w);
      end
    end
  end

  // Window age and saturating count
  assign sel       = row[hit_w];
  assign elapsed   = req.now_seconds - sel.start;
  assign expired   = elapsed > {16'd0, window_seconds};
  assign count_inc = (sel.count != COUNT_MAX) ? sel.count + 16'd1 : sel.count;

  // Count that the budget is taken against
  always_comb begin
    if (hit && !expired) begin
      count_eff = (req.mode == MODE_PEEK) ? sel.count : count_inc;
    end else begin
      count_eff = 16'd1;
    end
  end

  // Decision and new row
  always_comb begin
    new_row               = row;
    ctl.we                = 1'b0;
    ctl.res.allowed       = 1'b1;
    ctl.res.remaining     = message_limit;
    ctl.res.untracked     = 1'b0;
    if (hit) begin
      if (req.mode == MODE_PEEK) begin
        ctl.res.remaining = expired ? message_limit : budget_left(count_eff, message_limit);
      end else if (expired) begin
        new_row[hit_w].count = 16'd1;
        new_row[hit_w].start = req.now_seconds;
        ctl.we               = 1'b1;
        ctl.res.remaining    = budget_left(count_eff, message_limit);
      end else begin
        new_row[hit_w].count = count_inc;
        ctl.we               = 1'b1;
        ctl.res.allowed      = !(count_inc > message_limit);
        ctl.res.remaining    = budget_left(count_eff, message_limit);
      end
    end else if (req.mode == MODE_CHECK) begin
      if (have_free) begin
        new_row[free_w].valid = 1'b1;
        new_row[free_w].key   = req.user_key;
        new_row[free_w].count = 16'd1;
        new_row[free_w].start = req.now_seconds;
        ctl.we                = 1'b1;
        ctl.res.remaining     = budget_left(count_eff, message_limit);
      end else begin
        ctl.res.untracked = 1'b1;
      end
    end
  end

endmodule
